>>> src/aes_ctr_pkg.sv
// Package with AES tables, round functions and register codes for the CTR keystream block.
package aes_ctr_pkg;

  localparam int unsigned KeyRounds = 14;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte b of the state sits at bits 8b+7:8b
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

>>> src/aes256_ctr_keystream.sv
// AES-256 counter-mode keystream generator, one cipher round per pipeline stage after a key-addition stage.
// Each accepted request carries a 64-bit start counter and yields BLOCKS_PER_ITEM keystream
// blocks, one per cycle while the output is not stalled by m_axis_tready; a new request can be
// taken in the cycle that the last block of the previous one enters the 15-stage round pipeline.
// Each block is registered through st_q[0] to st_q[14]. Every key register write re-expands the
// schedule one word per cycle, with s_axis_tready low until the expansion is done.
module aes256_ctr_keystream
  import aes_ctr_pkg::*;
#(
  parameter int unsigned BLOCKS_PER_ITEM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RegIdxW-1:0]   cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // start_counter
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [135:0]         m_axis_tdata,  // stream_low, stream_high, block_index, pad
  output logic                 m_axis_tlast   // last_block
);

  localparam int unsigned PosW = (BLOCKS_PER_ITEM > 1) ? $clog2(BLOCKS_PER_ITEM) : 1;
  localparam int unsigned NStg = KeyRounds + 1;
  localparam logic [PosW-1:0] LastPos = PosW'(BLOCKS_PER_ITEM - 1);

  logic [63:0]  key_q [4];
  logic [63:0]  nonce_q;
  logic [127:0] rk_q [NStg];

  // key expansion
  logic         exp_load_q, exp_run_q;
  logic [5:0]   exp_cnt_q;
  logic [7:0]   rcon_q;
  logic [31:0]  win_q [8];
  logic [31:0]  exp_t, exp_nw;

  always_comb begin
    exp_t = win_q[7];
    if (exp_cnt_q[2:0] == 3'd0) begin
      exp_t = sub_word({win_q[7][7:0], win_q[7][31:8]}) ^ {24'd0, rcon_q};
    end else if (exp_cnt_q[2:0] == 3'd4) begin
      exp_t = sub_word(win_q[7]);
    end
    exp_nw = win_q[0] ^ exp_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_load_q <= 1'b0;
      exp_run_q  <= 1'b0;
      exp_cnt_q  <= '0;
    end else begin
      exp_load_q <= cfg_we_i && (cfg_idx_i == REG_KEY0 || cfg_idx_i == REG_KEY1 ||
                                 cfg_idx_i == REG_KEY2 || cfg_idx_i == REG_KEY3);
      if (exp_load_q) begin
        exp_run_q <= 1'b1;
        exp_cnt_q <= 6'd8;
      end else if (exp_run_q) begin
        exp_cnt_q <= exp_cnt_q + 6'd1;
        if (exp_cnt_q == 6'd59) exp_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:  key_q[0] <= cfg_data_i;
        REG_KEY1:  key_q[1] <= cfg_data_i;
        REG_KEY2:  key_q[2] <= cfg_data_i;
        REG_KEY3:  key_q[3] <= cfg_data_i;
        REG_NONCE: nonce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_load_q) begin
      for (int i = 0; i < 4; i++) begin
        win_q[2*i]   <= key_q[i][31:0];
        win_q[2*i+1] <= key_q[i][63:32];
      end
      rk_q[0] <= {key_q[1], key_q[0]};
      rk_q[1] <= {key_q[3], key_q[2]};
      rcon_q  <= 8'h01;
    end else if (exp_run_q) begin
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= exp_nw;
      if (exp_cnt_q[2:0] == 3'd0) rcon_q <= xtime(rcon_q);
      if (exp_cnt_q[1:0] == 2'd3) begin
        rk_q[exp_cnt_q[5:2]] <= {exp_nw, win_q[7], win_q[6], win_q[5]};
      end
    end
  end

  // block generator and round pipeline
  logic            gen_act_q;
  logic [PosW-1:0] gen_pos_q;
  logic [63:0]     gen_cnt_q;
  logic            en, gen_done, s_acc;

  logic             vld_q  [NStg];
  logic [127:0]     st_q   [NStg];
  logic [2:0]       idx_q  [NStg];
  logic             last_q [NStg];

  assign en       = !vld_q[NStg-1] || m_axis_tready;
  assign gen_done = en && (gen_pos_q == LastPos);
  assign s_axis_tready = !exp_load_q && !exp_run_q && (!gen_act_q || gen_done);
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_act_q <= 1'b0;
      gen_pos_q <= '0;
      for (int i = 0; i < NStg; i++) vld_q[i] <= 1'b0;
    end else begin
      if (s_acc) begin
        gen_act_q <= 1'b1;
        gen_pos_q <= '0;
      end else if (gen_act_q && en) begin
        gen_pos_q <= gen_pos_q + PosW'(1);
        if (gen_pos_q == LastPos) gen_act_q <= 1'b0;
      end
      if (en) begin
        vld_q[0] <= gen_act_q;
        for (int i = 1; i < NStg; i++) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      gen_cnt_q <= s_axis_tdata;
    end else if (gen_act_q && en) begin
      gen_cnt_q <= gen_cnt_q + 64'd1;
    end
    if (en) begin
      st_q[0]   <= {nonce_q, gen_cnt_q} ^ rk_q[0];
      idx_q[0]  <= 3'(gen_pos_q);
      last_q[0] <= (gen_pos_q == LastPos);
      for (int i = 1; i < NStg; i++) begin
        if (i == NStg - 1) st_q[i] <= sub_shift(st_q[i-1]) ^ rk_q[i];
        else st_q[i] <= mix_columns(sub_shift(st_q[i-1])) ^ rk_q[i];
        idx_q[i]  <= idx_q[i-1];
        last_q[i] <= last_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {5'd0, idx_q[NStg-1], st_q[NStg-1]};
  assign m_axis_tlast  = last_q[NStg-1];

endmodule
